// ===== hw/rtl/pkrt_pkg.sv =====
// ----------------------------------------------------------------------------
// pkrt_pkg
// Shared types and constants of the per-key report throttle.
// ----------------------------------------------------------------------------
package pkrt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int KEY_W      = 24;
    localparam int TIME_W     = 64;
    localparam int SKIP_W     = 32;
    localparam int INTERVAL_W = 32;
    localparam int LEN_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int ENTRY_W    = KEY_W + TIME_W + SKIP_W;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000000);
    localparam logic [SKIP_W-1:0]     SKIP_MAX       = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC,
        ST_JUDGE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] last_time;
        logic [SKIP_W-1:0] skip_count;
    } t_entry;

endpackage

// ===== hw/rtl/pkrt_in_if.sv =====
// ----------------------------------------------------------------------------
// pkrt_in_if
// Report event channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
interface pkrt_in_if;
    logic                              valid;
    logic                              ready;
    logic                              host_connected;
    logic [pkrt_pkg::LEN_W-1:0]        report_length;
    logic [pkrt_pkg::BYTE_W-1:0]       first_byte;
    logic                              has_report_id;
    logic [pkrt_pkg::BYTE_W-1:0]       device_address;
    logic [pkrt_pkg::BYTE_W-1:0]       interface_instance;
    logic [pkrt_pkg::TIME_W-1:0]       now_us;

    modport source (
        output valid, host_connected, report_length, first_byte, has_report_id,
               device_address, interface_instance, now_us,
        input  ready
    );

    modport sink (
        input  valid, host_connected, report_length, first_byte, has_report_id,
               device_address, interface_instance, now_us,
        output ready
    );
endinterface

// ===== hw/rtl/pkrt_out_if.sv =====
// ----------------------------------------------------------------------------
// pkrt_out_if
// Verdict channel: valid/ready handshake with the throttle decision.
// ----------------------------------------------------------------------------
interface pkrt_out_if;
    logic                          valid;
    logic                          ready;
    logic                          pass;
    logic [pkrt_pkg::SKIP_W-1:0]   skipped_before;
    logic                          tracked;

    modport source (
        output valid, pass, skipped_before, tracked,
        input  ready
    );

    modport sink (
        input  valid, pass, skipped_before, tracked,
        output ready
    );
endinterface

// ===== hw/rtl/pkrt_ram.sv =====
// ----------------------------------------------------------------------------
// pkrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pkrt_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/per_key_report_throttle_core.sv =====
// ----------------------------------------------------------------------------
// per_key_report_throttle_core
// Per-key report rate limiter with a sequentially scanned entry table.
// ----------------------------------------------------------------------------
// Each report event is keyed by (device address, interface instance, report
// id) and looked up in a table of TABLE_ENTRIES entries held in one RAM. The
// lookup reads one entry per cycle through the RAM's single read port and
// compares it against the key. For a new key the verdict follows a scan of
// every entry in use and then the ALLOC and JUDGE states, or only the scan
// when the table is full; a hit ends the scan early. A dropped report (host
// not connected or zero length) is answered in the cycle after it is taken.
// One event is handled at a time: the input is not ready until the verdict
// has been taken. A tracked key passes once interval_us microseconds have
// elapsed since its last pass (64-bit wrapping difference); otherwise its
// skip count is raised, saturating, and reported and cleared on the next
// pass. Untracked keys pass once the table is full.
// Write interval_us only while no event is in flight.
// ----------------------------------------------------------------------------
module per_key_report_throttle_core #(
    parameter int TABLE_ENTRIES = pkrt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pkrt_pkg::INTERVAL_W-1:0]   i_cfg_wdata,
    pkrt_in_if.sink                           i_evt,
    pkrt_out_if.source                        o_rpt
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    pkrt_pkg::t_state r_state, n_state;

    logic [pkrt_pkg::INTERVAL_W-1:0] r_interval;
    logic [CNT_W-1:0]                r_used, n_used;
    logic [CNT_W-1:0]                r_idx, n_idx;
    logic                            r_pend, n_pend;
    logic [IDX_W-1:0]                r_pend_idx, n_pend_idx;
    logic [IDX_W-1:0]                r_slot, n_slot;
    logic [pkrt_pkg::KEY_W-1:0]      r_key, n_key;
    logic [pkrt_pkg::TIME_W-1:0]     r_now, n_now;
    logic [pkrt_pkg::TIME_W-1:0]     r_last, n_last;
    logic [pkrt_pkg::SKIP_W-1:0]     r_skip, n_skip;

    logic                            r_ovalid, n_ovalid;
    logic                            r_opass, n_opass;
    logic [pkrt_pkg::SKIP_W-1:0]     r_oskip, n_oskip;
    logic                            r_otracked, n_otracked;

    logic                            evt_take;
    logic                            evt_drop;
    logic                            issue;
    logic                            hit;
    logic                            room;
    logic                            suppress;
    logic [pkrt_pkg::TIME_W-1:0]     elapsed;
    pkrt_pkg::t_entry                rd_entry;
    pkrt_pkg::t_entry                wr_entry;
    logic [pkrt_pkg::ENTRY_W-1:0]    rdata;
    logic                            ram_we;

    assign i_evt.ready = (r_state == pkrt_pkg::ST_IDLE) && !r_ovalid;
    assign evt_take    = i_evt.valid && i_evt.ready;
    assign evt_drop    = !i_evt.host_connected || (i_evt.report_length == '0);

    assign rd_entry = pkrt_pkg::t_entry'(rdata);
    assign issue    = r_idx < r_used;
    assign hit      = r_pend && (rd_entry.key == r_key);
    assign room     = r_used < CNT_W'(TABLE_ENTRIES);
    assign elapsed  = r_now - r_last;
    assign suppress = elapsed < pkrt_pkg::TIME_W'(r_interval);

    pkrt_ram #(
        .WIDTH (pkrt_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (wr_entry),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pkrt_pkg::ST_IDLE: begin
                if (evt_take && !evt_drop) begin
                    n_state = pkrt_pkg::ST_SCAN;
                end
            end
            pkrt_pkg::ST_SCAN: begin
                if (hit) begin
                    n_state = pkrt_pkg::ST_JUDGE;
                end else if (!issue && !r_pend) begin
                    n_state = room ? pkrt_pkg::ST_ALLOC : pkrt_pkg::ST_IDLE;
                end
            end
            pkrt_pkg::ST_ALLOC: n_state = pkrt_pkg::ST_JUDGE;
            pkrt_pkg::ST_JUDGE: n_state = pkrt_pkg::ST_IDLE;
            default:            n_state = pkrt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_used     = r_used;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_slot     = r_slot;
        n_key      = r_key;
        n_now      = r_now;
        n_last     = r_last;
        n_skip     = r_skip;
        n_ovalid   = r_ovalid && !o_rpt.ready;
        n_opass    = r_opass;
        n_oskip    = r_oskip;
        n_otracked = r_otracked;
        ram_we     = 1'b0;
        wr_entry.key        = r_key;
        wr_entry.last_time  = r_now;
        wr_entry.skip_count = '0;
        if (suppress) begin
            wr_entry.last_time  = r_last;
            wr_entry.skip_count = (r_skip == pkrt_pkg::SKIP_MAX) ? r_skip
                                                                 : r_skip + 1'b1;
        end

        unique case (r_state)
            pkrt_pkg::ST_IDLE: begin
                if (evt_take) begin
                    n_key  = {i_evt.device_address, i_evt.interface_instance,
                              i_evt.has_report_id ? i_evt.first_byte
                                                  : pkrt_pkg::BYTE_W'(0)};
                    n_now  = i_evt.now_us;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    if (evt_drop) begin
                        n_ovalid   = 1'b1;
                        n_opass    = 1'b0;
                        n_oskip    = '0;
                        n_otracked = 1'b0;
                    end
                end
            end
            pkrt_pkg::ST_SCAN: begin
                if (hit) begin
                    n_slot = r_pend_idx;
                    n_last = rd_entry.last_time;
                    n_skip = rd_entry.skip_count;
                end else if (!issue && !r_pend) begin
                    if (!room) begin
                        n_ovalid   = 1'b1;
                        n_opass    = 1'b1;
                        n_oskip    = '0;
                        n_otracked = 1'b0;
                    end
                end else begin
                    n_pend     = issue;
                    n_pend_idx = r_idx[IDX_W-1:0];
                    if (issue) begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end
            end
            pkrt_pkg::ST_ALLOC: begin
                n_slot = r_used[IDX_W-1:0];
                n_used = r_used + CNT_W'(1);
                n_last = '0;
                n_skip = '0;
            end
            pkrt_pkg::ST_JUDGE: begin
                ram_we     = 1'b1;
                n_ovalid   = 1'b1;
                n_opass    = !suppress;
                n_oskip    = suppress ? '0 : r_skip;
                n_otracked = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pkrt_pkg::ST_IDLE;
            r_interval <= pkrt_pkg::INTERVAL_RESET;
            r_used     <= '0;
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_used     <= n_used;
            r_idx      <= n_idx;
            r_pend     <= n_pend;
            r_ovalid   <= n_ovalid;
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_slot     <= n_slot;
        r_key      <= n_key;
        r_now      <= n_now;
        r_last     <= n_last;
        r_skip     <= n_skip;
        r_opass    <= n_opass;
        r_oskip    <= n_oskip;
        r_otracked <= n_otracked;
    end

    assign o_rpt.valid          = r_ovalid;
    assign o_rpt.pass           = r_opass;
    assign o_rpt.skipped_before = r_oskip;
    assign o_rpt.tracked        = r_otracked;

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_evt.valid && i_evt.ready) |=> !i_evt.ready)
        else $error("event accepted while another is in flight");

    a_table_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_used_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != pkrt_pkg::ST_ALLOC) |=> (r_used == $past(r_used)))
        else $error("entry count changed outside allocation");

    a_skip_on_pass_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rpt.valid && (!o_rpt.pass || !o_rpt.tracked)) |-> (o_rpt.skipped_before == '0))
        else $error("skip count reported without a tracked pass");
`endif

endmodule
